[src/pae_pkg.sv]
// Shared types, constants and register indexes for the preferential attachment edge generator.
package pae_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int DEF_MAX_NODES      = 1024;
    localparam int DEF_MAX_LINKS      = 8;
    localparam int DEF_ENDPOINT_DEPTH = 16384;

    // Configuration port.
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 11;
    localparam int NODE_COUNT_W = 11;
    localparam int LINK_CFG_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINKS_PER_NODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEED_NODES     = 2'd2;

    localparam logic [NODE_COUNT_W-1:0] RST_NODE_COUNT     = 11'd1024;
    localparam logic [LINK_CFG_W-1:0]   RST_LINKS_PER_NODE = 4'd2;
    localparam logic [LINK_CFG_W-1:0]   RST_SEED_NODES     = 4'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_WR_NEW,
        ST_WR_OLD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;   // input word accepted
        logic check;   // candidate endpoint is in the read register
        logic wr_new;  // write newer node of the edge
        logic wr_old;  // write older node, bump edge count
        logic emit;    // load the output register
    } t_dp_cmd;

    typedef struct packed {
        logic start_seed;    // accepted word makes a seed edge
        logic start_attach;  // accepted word makes an attachment attempt
        logic reject;        // candidate is the node itself or already linked
        logic out_free;      // output register can take a word this cycle
    } t_dp_status;

endpackage

[src/pae_ctrl.sv]
// Controller state machine: sequences store reads, store writes and the output load.
module pae_ctrl
    import pae_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.start_seed) begin
                        n_state = ST_WR_NEW;
                    end else if (i_status.start_attach) begin
                        n_state = ST_READ;
                    end
                end
            end
            ST_READ:   n_state = ST_CHECK;
            ST_CHECK: begin
                n_state = i_status.reject ? ST_IDLE : ST_WR_NEW;
            end
            ST_WR_NEW: n_state = ST_WR_OLD;
            ST_WR_OLD: n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_cmd.start = i_in_valid;
            end
            ST_CHECK:  o_cmd.check  = 1'b1;
            ST_WR_NEW: o_cmd.wr_new = 1'b1;
            ST_WR_OLD: o_cmd.wr_old = 1'b1;
            ST_EMIT:   o_cmd.emit   = i_status.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

[src/pae_datapath.sv]
// Datapath: config registers, graph state, endpoint memory, partner compare, output register.
module pae_datapath
    import pae_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int MAX_LINKS      = DEF_MAX_LINKS,
    parameter int ENDPOINT_DEPTH = DEF_ENDPOINT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic [31:0]                  i_random_fraction,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [$clog2(MAX_NODES)-1:0] o_node_low,
    output logic [$clog2(MAX_NODES)-1:0] o_node_high,
    output logic                         o_last
);

    localparam int ID_W   = $clog2(MAX_NODES);
    localparam int NODE_W = $clog2(MAX_NODES + 1);
    localparam int LNK_W  = $clog2(MAX_LINKS + 1);
    localparam int AW     = $clog2(ENDPOINT_DEPTH);
    localparam int EC_W   = $clog2(ENDPOINT_DEPTH / 2 + 1);
    localparam int EP_W   = $clog2(ENDPOINT_DEPTH + 2);
    localparam int XW0    = (NODE_W > NODE_COUNT_W) ? NODE_W : NODE_COUNT_W;
    localparam int XW     = (XW0 > LNK_W) ? XW0 : LNK_W;
    localparam int PW     = 32 + EP_W;

    // Configuration
    logic [NODE_COUNT_W-1:0] r_node_count;
    logic [LINK_CFG_W-1:0]   r_links_per_node;
    logic [LINK_CFG_W-1:0]   r_seed_nodes;

    // Graph state
    logic [NODE_W-1:0] r_node;
    logic [LNK_W-1:0]  r_partner;
    logic [LNK_W-1:0]  r_links;
    logic [EC_W-1:0]   r_ec;
    logic              r_finished;
    logic [ID_W-1:0]   r_chosen [MAX_LINKS];

    // Attempt and edge registers
    logic [AW-1:0]   r_idx;
    logic            r_pick_zero;
    logic [ID_W-1:0] r_rd_data;
    logic [ID_W-1:0] r_edge_new;
    logic [ID_W-1:0] r_edge_old;
    logic            r_edge_last;

    logic [ID_W-1:0] mem_endpoint [ENDPOINT_DEPTH];

    // Output register
    logic            r_out_valid;
    logic [ID_W-1:0] r_out_low;
    logic [ID_W-1:0] r_out_high;
    logic            r_out_last;

    logic [XW-1:0] w_nc_raw, w_nc;
    logic [XW-1:0] w_seed_raw, w_seed_a, w_seed_b, w_seed;
    logic [XW-1:0] w_lnk_raw, w_lnk_a, w_lnk;
    logic [XW-1:0] w_node, w_partner, w_links;
    logic [XW-1:0] w_node1, w_partner1, w_node2, w_links_inc;
    logic          w_seed_adv, w_is_seed, w_seed_last, w_link_adv, w_no_node;
    logic [EP_W-1:0] w_pos, w_ep;
    logic [PW-1:0]   w_prod;
    logic            w_store_ok;
    logic [ID_W-1:0] w_cand;
    logic            w_hit, w_reject, w_attach_last, w_attach_done;
    logic            w_out_free;

    // Effective register values after saturation
    always_comb begin
        w_nc_raw   = XW'(r_node_count);
        w_nc       = (w_nc_raw > XW'(MAX_NODES)) ? XW'(MAX_NODES) :
                     (w_nc_raw < XW'(2)) ? XW'(2) : w_nc_raw;
        w_seed_raw = XW'(r_seed_nodes);
        w_seed_a   = (w_seed_raw > XW'(MAX_LINKS)) ? XW'(MAX_LINKS) : w_seed_raw;
        w_seed_b   = (w_seed_a == '0) ? XW'(1) : w_seed_a;
        w_seed     = (w_seed_b > w_nc) ? w_nc : w_seed_b;
        w_lnk_raw  = XW'(r_links_per_node);
        w_lnk_a    = (w_lnk_raw > w_seed) ? w_seed : w_lnk_raw;
        w_lnk      = (w_lnk_a == '0) ? XW'(1) : w_lnk_a;
    end

    // Step classification from the current state
    always_comb begin
        w_node      = XW'(r_node);
        w_partner   = XW'(r_partner);
        w_links     = XW'(r_links);
        w_seed_adv  = (w_node < w_seed) && (w_partner >= w_node);
        w_node1     = w_seed_adv ? w_node + XW'(1) : w_node;
        w_partner1  = w_seed_adv ? '0 : w_partner;
        w_is_seed   = w_node1 < w_seed;
        w_seed_last = (w_seed == w_nc) && (w_node1 + XW'(1) == w_seed) &&
                      (w_partner1 + XW'(1) == w_node1);
        w_link_adv  = w_links >= w_lnk;
        w_node2     = w_link_adv ? w_node1 + XW'(1) : w_node1;
        w_no_node   = w_node2 >= w_nc;
    end

    // Pick index: fraction times endpoint count, upper bits
    always_comb begin
        w_pos      = EP_W'({r_ec, 1'b0});
        w_ep       = (w_pos > EP_W'(ENDPOINT_DEPTH)) ? EP_W'(ENDPOINT_DEPTH) : w_pos;
        w_prod     = PW'(i_random_fraction) * PW'(w_ep);
        w_store_ok = (w_pos + EP_W'(1)) < EP_W'(ENDPOINT_DEPTH);
    end

    // Candidate check against the node itself and the partners taken so far
    always_comb begin
        w_cand = r_pick_zero ? '0 : r_rd_data;
        w_hit  = 1'b0;
        for (int j = 0; j < MAX_LINKS; j++) begin
            if ((LNK_W'(j) < r_links) && (r_chosen[j] == w_cand)) begin
                w_hit = 1'b1;
            end
        end
        w_reject      = (XW'(w_cand) == w_node) || w_hit;
        w_links_inc   = w_links + XW'(1);
        w_attach_done = w_links_inc >= w_lnk;
        w_attach_last = w_attach_done && (w_node + XW'(1) >= w_nc);
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_status              = '0;
        o_status.start_seed   = !r_finished && w_is_seed;
        o_status.start_attach = !r_finished && !w_is_seed && !w_no_node;
        o_status.reject       = w_reject;
        o_status.out_free     = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count     <= RST_NODE_COUNT;
            r_links_per_node <= RST_LINKS_PER_NODE;
            r_seed_nodes     <= RST_SEED_NODES;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_NODE_COUNT:     r_node_count     <= i_cfg_wdata[NODE_COUNT_W-1:0];
                CFG_LINKS_PER_NODE: r_links_per_node <= i_cfg_wdata[LINK_CFG_W-1:0];
                CFG_SEED_NODES:     r_seed_nodes     <= i_cfg_wdata[LINK_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Graph state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= '0;
            r_partner  <= '0;
            r_links    <= '0;
            r_ec       <= '0;
            r_finished <= 1'b0;
        end else begin
            if (i_cmd.start && !r_finished) begin
                if (w_is_seed) begin
                    r_node    <= w_node1[NODE_W-1:0];
                    r_partner <= LNK_W'(w_partner1 + XW'(1));
                    if (w_seed_last) begin
                        r_finished <= 1'b1;
                    end
                end else begin
                    r_node    <= w_node2[NODE_W-1:0];
                    r_partner <= w_partner1[LNK_W-1:0];
                    r_links   <= w_link_adv ? '0 : r_links;
                    if (w_no_node) begin
                        r_finished <= 1'b1;
                    end
                end
            end
            if (i_cmd.check && !w_reject) begin
                if (w_attach_done && !w_attach_last) begin
                    r_node  <= NODE_W'(w_node + XW'(1));
                    r_links <= '0;
                end else begin
                    r_links <= w_links_inc[LNK_W-1:0];
                end
                if (w_attach_last) begin
                    r_finished <= 1'b1;
                end
            end
            if (i_cmd.wr_old && w_store_ok) begin
                r_ec <= EC_W'(r_ec + EC_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_LINKS; j++) begin
            if (i_cmd.check && !w_reject && (r_links == LNK_W'(j))) begin
                r_chosen[j] <= w_cand;
            end
        end
    end

    // Attempt and edge registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx       <= w_prod[32 +: AW];
            r_pick_zero <= (w_ep == '0);
            r_edge_new  <= w_node1[ID_W-1:0];
            r_edge_old  <= w_partner1[ID_W-1:0];
            r_edge_last <= w_seed_last;
        end
        if (i_cmd.check) begin
            r_edge_new  <= r_node[ID_W-1:0];
            r_edge_old  <= w_cand;
            r_edge_last <= w_attach_last;
        end
    end

    // Endpoint store: newer node at the even address, older at the odd one
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_new && w_store_ok) begin
            mem_endpoint[w_pos[AW-1:0]] <= r_edge_new;
        end
        if (i_cmd.wr_old && w_store_ok) begin
            mem_endpoint[{w_pos[AW-1:1], 1'b1}] <= r_edge_old;
        end
        r_rd_data <= mem_endpoint[r_idx];
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_low  <= (r_edge_new < r_edge_old) ? r_edge_new : r_edge_old;
            r_out_high <= (r_edge_new < r_edge_old) ? r_edge_old : r_edge_new;
            r_out_last <= r_edge_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_node_low  = r_out_low;
    assign o_node_high = r_out_high;
    assign o_last      = r_out_last;

endmodule

[src/preferential_attachment_edge_generator.sv]
// Barabasi-Albert graph generator: one random word in, at most one edge word out.
// Each accepted random word yields zero or one edge. The first words produce the edges of the
// complete graph on the seed nodes (the random value is ignored); later words pick a stored
// endpoint and either reject it or attach it to the current node. A seed edge is
// written to the endpoint memory and then loaded into the output register. An attachment reads
// a stored endpoint and checks it; a rejected one ends there, an accepted one is stored and
// loaded as a seed edge. A word that makes no attempt (node count reached or graph finished)
// yields no edge. These steps follow from the endpoint memory's registered read: one read per
// attempt and two writes per edge (newer node, then older node). A finished edge waits in the
// output register while the next word is accepted; if that register is still full when the
// next edge is ready, the block holds until it drains. The endpoint memory needs no clearing
// after reset.
module preferential_attachment_edge_generator
    import pae_pkg::*;
#(
    parameter int MAX_NODES      = DEF_MAX_NODES,
    parameter int MAX_LINKS      = DEF_MAX_LINKS,
    parameter int ENDPOINT_DEPTH = DEF_ENDPOINT_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [31:0]                  i_random_fraction,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [$clog2(MAX_NODES)-1:0] o_node_low,
    output logic [$clog2(MAX_NODES)-1:0] o_node_high,
    output logic                         o_last
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    pae_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    pae_datapath #(
        .MAX_NODES      (MAX_NODES),
        .MAX_LINKS      (MAX_LINKS),
        .ENDPOINT_DEPTH (ENDPOINT_DEPTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_random_fraction (i_random_fraction),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_node_low        (o_node_low),
        .o_node_high       (o_node_high),
        .o_last            (o_last)
    );

    // An edge never joins a node to itself, and low is ordered first.
    a_edge_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_node_low < o_node_high))
        else $error("edge word not strictly ordered");

    // Nothing follows the final edge.
    a_nothing_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last) |=> !o_out_valid)
        else $error("edge word after the final edge");

    // The older-node write always directly follows the newer-node write.
    a_write_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_old |-> $past(w_cmd.wr_new))
        else $error("endpoint write pair broken");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for the preferential attachment edge generator.
module tb_top;
    import pae_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_NODES   = DEF_MAX_NODES;
    localparam int MAX_LINKS   = DEF_MAX_LINKS;
    localparam int EP_DEPTH    = DEF_ENDPOINT_DEPTH;
    localparam int NODE_W      = $clog2(MAX_NODES);
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE      = 16;

    typedef struct packed {
        logic [NODE_W-1:0] node_low;
        logic [NODE_W-1:0] node_high;
        logic              last;
    } t_edge;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  rnd_valid = 1'b0;
    logic [31:0]           rnd_word = '0;
    logic                  edge_ready = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [NODE_W-1:0]     o_node_low;
    logic [NODE_W-1:0]     o_node_high;
    logic                  o_last;

    // Stimulus and expectations
    logic [31:0]  frac_q[$];
    t_edge        edge_q[$];
    bit           rnd_taken = 1'b0;
    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  n_edges = 0;
    int unsigned  n_errors = 0;
    int unsigned  n_cycles = 0;
    int unsigned  hold_left = 0;
    bit           hold_done = 1'b0;

    // Graph state mirrored from the block
    logic [10:0]       nodes_cfg;
    logic [3:0]        links_cfg;
    logic [3:0]        seed_cfg;
    logic [NODE_W-1:0] ep_store[EP_DEPTH];
    int unsigned       edge_cnt;
    int unsigned       cur_node;
    int unsigned       seed_peer;
    int unsigned       cur_links;
    int unsigned       peers[MAX_LINKS];
    bit                graph_done;

    preferential_attachment_edge_generator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_index       (cfg_index),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (rnd_valid),
        .o_in_ready        (o_in_ready),
        .i_random_fraction (rnd_word),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (edge_ready),
        .o_node_low        (o_node_low),
        .o_node_high       (o_node_high),
        .o_last            (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic record_edge(input int unsigned newer, input int unsigned older);
        if (2 * edge_cnt + 1 < EP_DEPTH) begin
            ep_store[2 * edge_cnt]     = NODE_W'(newer);
            ep_store[2 * edge_cnt + 1] = NODE_W'(older);
            edge_cnt++;
        end
    endtask

    task automatic expect_edge(input int unsigned a, input int unsigned b, input bit last);
        t_edge e;
        e.node_low  = NODE_W'(a < b ? a : b);
        e.node_high = NODE_W'(a < b ? b : a);
        e.last      = last;
        edge_q.push_back(e);
        if (last)
            graph_done = 1'b1;
    endtask

    // Work out the edge, if any, that one random word produces.
    task automatic predict_edge(input logic [31:0] frac);
        int unsigned nc, seed, links, endpoints, cand, node, j;
        logic [63:0] idx;
        bit          dup, last;
        if (graph_done)
            return;
        nc = nodes_cfg;
        if (nc > MAX_NODES) nc = MAX_NODES;
        if (nc < 2) nc = 2;
        seed = seed_cfg;
        if (seed > MAX_LINKS) seed = MAX_LINKS;
        if (seed < 1) seed = 1;
        if (seed > nc) seed = nc;
        links = links_cfg;
        if (links > seed) links = seed;
        if (links < 1) links = 1;

        // complete graph on the seed nodes; also re-entered if the seed size grows
        while (cur_node < seed && seed_peer >= cur_node) begin
            cur_node++;
            seed_peer = 0;
        end
        if (cur_node < seed) begin
            node = seed_peer;
            record_edge(cur_node, node);
            seed_peer++;
            last = (seed == nc) && (cur_node + 1 == seed) && (node + 1 == cur_node);
            expect_edge(cur_node, node, last);
            return;
        end

        if (cur_links >= links || cur_links > MAX_LINKS) begin
            cur_node++;
            cur_links = 0;
        end
        if (cur_node >= nc) begin
            graph_done = 1'b1;
            return;
        end

        endpoints = 2 * edge_cnt;
        if (endpoints > EP_DEPTH) endpoints = EP_DEPTH;
        if (endpoints == 0) begin
            cand = 0;
        end else begin
            idx = (64'(frac) * 64'(endpoints)) >> 32;
            if (idx >= endpoints) idx = endpoints - 1;
            cand = ep_store[idx];
        end

        if (cand == cur_node)
            return;
        dup = 1'b0;
        for (j = 0; j < cur_links && j < MAX_LINKS; j++)
            if (peers[j] == cand)
                dup = 1'b1;
        if (dup)
            return;

        if (cur_links < MAX_LINKS)
            peers[cur_links] = cand;
        cur_links++;
        record_edge(cur_node, cand);
        last = (cur_links >= links) && (cur_node + 1 >= nc);
        node = cur_node;
        if (cur_links >= links && !last) begin
            cur_node++;
            cur_links = 0;
        end
        expect_edge(node, cand, last);
    endtask

    function automatic logic [31:0] rand_fraction();
        case ($urandom_range(9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'($urandom_range(255));
            3:       return ~32'($urandom_range(255));
            default: return $urandom;
        endcase
    endfunction

    // All three registers back to back, then the mirror picks up the new values.
    task automatic configure(input logic [10:0] nodes_w, input logic [10:0] links_w,
                             input logic [10:0] seed_w);
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_NODE_COUNT;
        cfg_wdata <= nodes_w;
        @(negedge i_clk);
        cfg_index <= CFG_LINKS_PER_NODE;
        cfg_wdata <= links_w;
        @(negedge i_clk);
        cfg_index <= CFG_SEED_NODES;
        cfg_wdata <= seed_w;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        nodes_cfg = nodes_w;
        links_cfg = links_w[3:0];
        seed_cfg  = seed_w[3:0];
    endtask

    // Wait until every word is taken and every edge is out, then let the block settle.
    task automatic drain();
        while (frac_q.size() != 0 || rnd_valid)
            @(posedge i_clk);
        while (edge_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_random(input int unsigned count);
        repeat (count) frac_q.push_back(rand_fraction());
    endtask

    // Input side: acceptance at the rising edge, next word offered at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rnd_valid && o_in_ready) begin
            predict_edge(rnd_word);
            rnd_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && (!rnd_valid || rnd_taken)) begin
            rnd_taken = 1'b0;
            if (frac_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                rnd_valid <= 1'b1;
                rnd_word  <= frac_q.pop_front();
            end else begin
                rnd_valid <= 1'b0;
            end
        end
    end

    // Output side: random back-pressure plus one long hold-off to fill the block up.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
            edge_ready <= 1'b0;
        end else if (!hold_done && n_edges >= 80) begin
            hold_done = 1'b1;
            hold_left = 300;
            edge_ready <= 1'b0;
        end else begin
            edge_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_edge exp_e;
        if (i_rst_n && o_out_valid && edge_ready) begin
            n_edges++;
            if (edge_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected edge word: got low=%0d high=%0d last=%0b",
                         $time, o_node_low, o_node_high, o_last);
            end else begin
                exp_e = edge_q.pop_front();
                if (o_node_low !== exp_e.node_low) begin
                    n_errors++;
                    $display("%0t: node_low mismatch: expected %0d, got %0d",
                             $time, exp_e.node_low, o_node_low);
                end
                if (o_node_high !== exp_e.node_high) begin
                    n_errors++;
                    $display("%0t: node_high mismatch: expected %0d, got %0d",
                             $time, exp_e.node_high, o_node_high);
                end
                if (o_last !== exp_e.last) begin
                    n_errors++;
                    $display("%0t: last mismatch: expected %0b, got %0b",
                             $time, exp_e.last, o_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0]  warmup[5];
        logic [31:0]  corner[15];
        int unsigned  nc_end;
        int unsigned  batch;

        warmup = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA};
        corner = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h3333_3333, 32'hCCCC_CCCC, 32'h0F0F_0F0F, 32'hF0F0_F0F0,
                   32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000};

        nodes_cfg  = RST_NODE_COUNT;
        links_cfg  = RST_LINKS_PER_NODE;
        seed_cfg   = RST_SEED_NODES;
        edge_cnt   = 0;
        cur_node   = 0;
        seed_peer  = 0;
        cur_links  = 0;
        graph_done = 1'b0;
        foreach (peers[k]) peers[k] = 0;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Seed of one: the first pick sees an empty endpoint list. Node count and
        // links are over range and get clipped.
        send_idle_pct = 24;
        recv_idle_pct = 62;
        configure(11'h7FF, 11'h00F, 11'h000);
        foreach (warmup[k]) frac_q.push_back(warmup[k]);
        drain();

        // Seed grows to eight while the node counter is still below it, so the seed
        // clique is finished first; then eight links per node. Upper data bits are junk.
        configure(11'd1024, 11'h7F8, 11'h008);
        foreach (corner[k]) frac_q.push_back(corner[k]);
        push_random(300);
        drain();

        // Fewer links than the current node may already hold; seed over range.
        send_idle_pct = 62;
        recv_idle_pct = 24;
        configure(11'($urandom_range(1025, 2047)),
                  11'({$urandom_range(127), 4'($urandom_range(2, 7))}),
                  11'($urandom_range(9, 15)));
        push_random(460);
        drain();

        // Close the graph a few nodes on, at full rate, with links of zero clipped to one.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        nc_end = cur_node + 4;
        if (nc_end > MAX_NODES) nc_end = MAX_NODES;
        configure(11'(nc_end), 11'h000, 11'h003);
        for (batch = 0; batch < 20 && !graph_done; batch++) begin
            push_random(50);
            drain();
        end
        push_random(20);
        drain();

        if (n_errors == 0 && edge_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

[preferential_attachment_edge_generator.f]
src/pae_pkg.sv
src/pae_ctrl.sv
src/pae_datapath.sv
src/preferential_attachment_edge_generator.sv
dv/tb_top.sv
